// ===== rtl/skht_pkg.sv =====
`timescale 1ns / 1ps
package skht_pkg;
  localparam int MAX_KEY_DEF     = 512;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int SLOTS_DEF       = 512;
  localparam int KEY_STORE_DEF   = 8192;

  localparam logic [31:0] HASH_INIT  = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_RSVD   = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_PRESENT  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // command passed from the byte front end to the table engine
  typedef struct packed {
    logic        is_clear;
    logic        is_lookup;
    logic        too_long;
    logic [31:0] hash;
    logic [15:0] dest;
    logic        lower;
  } skht_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [15:0] dest;
    logic        lower;
  } skht_res_t;
endpackage

// ===== rtl/skht_front.sv =====
`timescale 1ns / 1ps
module skht_front #(
  parameter int MAX_KEY = 512
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               func,
  input  logic [7:0]               key_byte,
  input  logic                     last,
  input  logic [15:0]              dest_id,
  input  logic                     lower_flag,
  // key buffer write port and captured length, read by the back end
  output logic                     kb_we,
  output logic [$clog2(MAX_KEY)-1:0] kb_waddr,
  output logic [7:0]               kb_wdata,
  output logic [$clog2(MAX_KEY):0] key_len,
  output logic                     cmd_valid,
  output skht_pkg::skht_cmd_t      cmd,
  input  logic                     cmd_done
);
  import skht_pkg::*;
  localparam int LW = $clog2(MAX_KEY) + 1;

  logic [LW-1:0] len_r, len_nxt;
  logic [LW:0]   cnt_r, cnt_nxt;
  logic [31:0]   hash_r, hash_nxt;
  logic          busy_r, busy_nxt;
  skht_cmd_t     cmd_r, cmd_nxt;
  logic [31:0]   hx;
  logic          acc, keyb;

  // the back end reads the key buffer, so hold new bytes until it is done
  assign full     = busy_r;
  assign acc      = push && !busy_r;
  assign keyb     = acc && (func == FN_INSERT || func == FN_LOOKUP);
  assign hx       = (hash_r ^ {24'd0, key_byte}) * HASH_PRIME;
  assign kb_we    = keyb && (cnt_r < (LW+1)'(MAX_KEY));
  assign kb_waddr = cnt_r[LW-2:0];
  assign kb_wdata = key_byte;
  assign key_len  = len_r;
  assign cmd_valid = busy_r;
  assign cmd      = cmd_r;

  always_comb begin
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    hash_nxt = hash_r;
    busy_nxt = busy_r;
    cmd_nxt  = cmd_r;
    if (busy_r && cmd_done) busy_nxt = 1'b0;
    if (acc && func == FN_CLEAR) begin
      cnt_nxt  = '0;
      hash_nxt = HASH_INIT;
      busy_nxt = 1'b1;
      cmd_nxt  = '{is_clear: 1'b1, is_lookup: 1'b0, too_long: 1'b0,
                   hash: '0, dest: '0, lower: 1'b0};
    end else if (keyb) begin
      if (cnt_r < (LW+1)'(MAX_KEY)) cnt_nxt = cnt_r + 1'b1;
      else cnt_nxt = (LW+1)'(MAX_KEY + 1);
      hash_nxt = hx;
      if (last) begin
        len_nxt  = cnt_nxt[LW-1:0];
        busy_nxt = 1'b1;
        cmd_nxt  = '{is_clear: 1'b0, is_lookup: func == FN_LOOKUP,
                     too_long: cnt_nxt > (LW+1)'(MAX_KEY), hash: hx,
                     dest: dest_id, lower: lower_flag};
        cnt_nxt  = '0;
        hash_nxt = HASH_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      hash_r <= HASH_INIT;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      hash_r <= hash_nxt;
      busy_r <= busy_nxt;
    end
    len_r <= len_nxt;
    cmd_r <= cmd_nxt;
  end
endmodule

// ===== rtl/skht_back.sv =====
`timescale 1ns / 1ps
module skht_back #(
  parameter int MAX_KEY     = 512,
  parameter int MAX_ENTRIES = 256,
  parameter int SLOTS       = 512,
  parameter int KEY_STORE   = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       kb_we,
  input  logic [$clog2(MAX_KEY)-1:0] kb_waddr,
  input  logic [7:0]                 kb_wdata,
  input  logic [$clog2(MAX_KEY):0]   key_len,
  input  logic                       cmd_valid,
  input  skht_pkg::skht_cmd_t        cmd,
  output logic                       cmd_done,
  output logic                       res_valid,
  output skht_pkg::skht_res_t        res,
  input  logic                       res_ready
);
  import skht_pkg::*;
  localparam int KW = $clog2(MAX_KEY);
  localparam int LW = KW + 1;
  localparam int SW = $clog2(SLOTS);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int OW = $clog2(KEY_STORE);
  localparam int UW = $clog2(KEY_STORE + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WIPE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCHK  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_ECHK  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_COPY  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [7:0]    kbuf [MAX_KEY];
  logic [EW:0]   slot_mem [SLOTS];
  logic [OW-1:0] eoff_mem [MAX_ENTRIES];
  logic [LW-1:0] elen_mem [MAX_ENTRIES];
  logic [15:0]   edst_mem [MAX_ENTRIES];
  logic          elow_mem [MAX_ENTRIES];
  logic [7:0]    kst_mem  [KEY_STORE];

  logic [3:0]    st_r, st_nxt;
  logic [SW:0]   wp_r, wp_nxt;      // wipe pointer; the wipe ends on the last slot index
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW:0]   probes_r, probes_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic [UW-1:0] used_r, used_nxt;
  skht_res_t     res_r, res_nxt;
  logic          rv_r, rv_nxt;

  logic [EW:0]   slot_q;
  logic [OW-1:0] eoff_q;
  logic [LW-1:0] elen_q;
  logic [15:0]   edst_q;
  logic          elow_q;
  logic [7:0]    kst_q, kb_q;
  logic [OW:0]   saddr;

  logic          sl_we;
  logic [SW-1:0] sl_wa;
  logic [EW:0]   sl_wd;
  logic          en_we, ks_we;
  logic [UW-1:0] ks_wa;
  logic [KW-1:0] kb_ra;
  logic [OW-1:0] ks_ra;

  assign res_valid = rv_r;
  assign res       = res_r;
  assign saddr     = {1'b0, eoff_q} + (OW+1)'(j_r);

  always_ff @(posedge clk) begin
    if (kb_we) kbuf[kb_waddr] <= kb_wdata;
    kb_q <= kbuf[kb_ra];
  end
  always_ff @(posedge clk) begin
    if (sl_we) slot_mem[sl_wa] <= sl_wd;
    slot_q <= slot_mem[slot_nxt];
  end
  always_ff @(posedge clk) begin
    if (en_we) begin
      eoff_mem[ecnt_r[EW-1:0]] <= used_r[OW-1:0];
      elen_mem[ecnt_r[EW-1:0]] <= key_len;
      edst_mem[ecnt_r[EW-1:0]] <= cmd.dest;
      elow_mem[ecnt_r[EW-1:0]] <= cmd.lower;
    end
    eoff_q <= eoff_mem[ent_nxt];
    elen_q <= elen_mem[ent_nxt];
    edst_q <= edst_mem[ent_nxt];
    elow_q <= elow_mem[ent_nxt];
  end
  always_ff @(posedge clk) begin
    if (ks_we) kst_mem[ks_wa[OW-1:0]] <= kb_q;
    kst_q <= kst_mem[ks_ra];
  end

  always_comb begin
    st_nxt     = st_r;
    wp_nxt     = wp_r;
    slot_nxt   = slot_r;
    probes_nxt = probes_r;
    ent_nxt    = ent_r;
    j_nxt      = j_r;
    ecnt_nxt   = ecnt_r;
    used_nxt   = used_r;
    res_nxt    = res_r;
    rv_nxt     = rv_r;
    cmd_done   = 1'b0;
    sl_we      = 1'b0;
    sl_wa      = wp_r[SW-1:0];
    sl_wd      = '0;
    en_we      = 1'b0;
    ks_we      = 1'b0;
    ks_wa      = used_r + UW'(j_r) - 1'b1;
    kb_ra      = j_r[KW-1:0];
    ks_ra      = saddr[OW-1:0];
    if (rv_r && res_ready) rv_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid && !rv_r) begin
          res_nxt = '{status: ST_FULL, entry_index: '0, dest: '0, lower: 1'b0};
          if (cmd.is_clear) begin
            wp_nxt = '0;
            st_nxt = S_WIPE;
          end else if (cmd.too_long) begin
            st_nxt = S_OUT;
          end else begin
            slot_nxt   = cmd.hash[SW-1:0];
            probes_nxt = '0;
            st_nxt     = S_SRD;
          end
        end
      end
      S_WIPE: begin
        // one slot a cycle
        sl_we  = 1'b1;
        wp_nxt = wp_r + 1'b1;
        if (wp_r == (SW+1)'(SLOTS - 1)) begin
          ecnt_nxt = '0;
          used_nxt = '0;
          res_nxt  = '{status: ST_CLEARED, entry_index: '0, dest: '0, lower: 1'b0};
          st_nxt = S_OUT;
        end
      end
      S_SRD: st_nxt = S_SCHK;
      S_SCHK: begin
        if (slot_q == '0) begin
          if (cmd.is_lookup) begin
            res_nxt.status = ST_MISS;
            st_nxt = S_OUT;
          end else if (ecnt_r >= CW'(MAX_ENTRIES) ||
                       UW'(key_len) > UW'(KEY_STORE) - used_r) begin
            st_nxt = S_OUT;
          end else begin
            j_nxt  = '0;
            st_nxt = S_COPY;
          end
        end else begin
          ent_nxt = slot_q[EW-1:0] - 1'b1;
          st_nxt  = S_ERD;
        end
      end
      S_ERD: st_nxt = S_ECHK;
      S_ECHK: begin
        if (elen_q == key_len) begin
          j_nxt  = '0;
          st_nxt = S_CMP;
        end else begin
          st_nxt = S_CCHK;
          j_nxt  = '1;
        end
      end
      S_CMP: begin
        // fetch store and buffer bytes at j, compare next cycle
        kb_ra  = j_r[KW-1:0];
        ks_ra  = saddr[OW-1:0];
        if (j_r == key_len) begin
          res_nxt = '{status: cmd.is_lookup ? ST_HIT : ST_PRESENT,
                      entry_index: 8'(ent_r), dest: edst_q, lower: elow_q};
          st_nxt = S_OUT;
        end else st_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (j_r != '1 && kst_q == kb_q) begin
          j_nxt  = j_r + 1'b1;
          st_nxt = S_CMP;
        end else begin
          // mismatch: next slot
          probes_nxt = probes_r + 1'b1;
          slot_nxt   = slot_r + 1'b1;
          if (probes_r == (SW+1)'(SLOTS - 1)) begin
            // no empty slot anywhere: a lookup still misses
            if (cmd.is_lookup) res_nxt.status = ST_MISS;
            st_nxt = S_OUT;
          end else st_nxt = S_SRD;
        end
      end
      S_COPY: begin
        // read byte j, write previous byte
        kb_ra = j_r[KW-1:0];
        ks_we = j_r != '0;
        j_nxt = j_r + 1'b1;
        if (j_r == key_len) begin
          en_we = 1'b1;
          sl_we = 1'b1;
          sl_wa = slot_r;
          sl_wd = (EW+1)'(ecnt_r) + 1'b1;
          res_nxt = '{status: ST_INSERTED, entry_index: 8'(ecnt_r),
                      dest: cmd.dest, lower: cmd.lower};
          ecnt_nxt = ecnt_r + 1'b1;
          used_nxt = used_r + UW'(key_len);
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        rv_nxt   = 1'b1;
        cmd_done = 1'b1;
        st_nxt   = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_WIPE;
      wp_r   <= '0;
      ecnt_r <= '0;
      used_r <= '0;
      rv_r   <= 1'b0;
    end else begin
      // the reset wipe answers only a clear that came in while it ran
      st_r   <= (st_r == S_WIPE && st_nxt == S_OUT && !(cmd_valid && cmd.is_clear)) ?
                S_IDLE : st_nxt;
      wp_r   <= wp_nxt;
      ecnt_r <= ecnt_nxt;
      used_r <= used_nxt;
      rv_r   <= rv_nxt;
    end
    slot_r   <= slot_nxt;
    probes_r <= probes_nxt;
    ent_r    <= ent_nxt;
    j_r      <= j_nxt;
    res_r    <= res_nxt;
  end
endmodule

// ===== rtl/string_key_hash_table.sv =====
`timescale 1ns / 1ps
// Byte-string hash table. Keys arrive one byte per word (push/full); bytes
// are taken one per cycle while full is low and hashed with FNV-1a. On the
// last byte, or on a clear, full rises until the table engine finishes: each
// lookup probe reads the slot, then the entry, then compares the key byte by
// byte (a byte is fetched in one state and compared in the next), an insert
// also copies the key into the key store, and a clear wipes every slot of the
// slot table. After reset the slot table is wiped before the first command is
// executed. Results come out through a one-word register (empty/pop).
module string_key_hash_table #(
  parameter int MAX_KEY     = skht_pkg::MAX_KEY_DEF,
  parameter int MAX_ENTRIES = skht_pkg::MAX_ENTRIES_DEF,
  parameter int SLOTS       = skht_pkg::SLOTS_DEF,
  parameter int KEY_STORE   = skht_pkg::KEY_STORE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last,
  input  logic [15:0] in_dest_id,
  input  logic        in_lower_flag,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [15:0] out_dest_out,
  output logic        out_lower_out
);
  import skht_pkg::*;

  logic                       kb_we, cmd_valid, cmd_done, res_valid;
  logic [$clog2(MAX_KEY)-1:0] kb_waddr;
  logic [7:0]                 kb_wdata;
  logic [$clog2(MAX_KEY):0]   key_len;
  skht_cmd_t                  cmd;
  skht_res_t                  res;

  skht_front #(.MAX_KEY(MAX_KEY)) u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .func(in_func),
    .key_byte(in_key_byte), .last(in_last), .dest_id(in_dest_id),
    .lower_flag(in_lower_flag), .kb_we, .kb_waddr, .kb_wdata, .key_len,
    .cmd_valid, .cmd, .cmd_done
  );

  skht_back #(.MAX_KEY(MAX_KEY), .MAX_ENTRIES(MAX_ENTRIES), .SLOTS(SLOTS),
              .KEY_STORE(KEY_STORE)) u_back (
    .clk, .rst_n, .kb_we, .kb_waddr, .kb_wdata, .key_len, .cmd_valid, .cmd,
    .cmd_done, .res_valid, .res, .res_ready(out_pop)
  );

  assign out_empty       = !res_valid;
  assign out_status      = res.status;
  assign out_entry_index = res.entry_index;
  assign out_dest_out    = res.dest;
  assign out_lower_out   = res.lower;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= ST_CLEARED) else $error("bad status");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_done |-> cmd_valid) else $error("done without command");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("result lost");
endmodule

// ===== verif/string_key_hash_table_tb.sv =====
`timescale 1ns / 1ps
module string_key_hash_table_tb;
  import skht_pkg::*;

  localparam int KEY_MAX   = MAX_KEY_DEF;
  localparam int ENT_MAX   = MAX_ENTRIES_DEF;
  localparam int SLOT_N    = SLOTS_DEF;
  localparam int STORE_MAX = KEY_STORE_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef logic [7:0] key_t[$];

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  kbyte;
    logic        last;
    logic [15:0] dest;
    logic        lower;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_func = FN_CLEAR;
  logic [7:0]  in_key_byte = '0;
  logic        in_last = 1'b0;
  logic [15:0] in_dest_id = '0;
  logic        in_lower_flag = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_entry_index;
  logic [15:0] out_dest_out;
  logic        out_lower_out;

  string_key_hash_table dut (.*);

  always #5 clk = ~clk;

  key_word_t  word_q[$];
  skht_res_t  lookup_exp_q[$];
  int         errors = 0;
  int         words_taken = 0;

  // table shadow
  logic [7:0]  kbuf[KEY_MAX];
  int unsigned klen;
  logic [31:0] khash;
  int unsigned slot_tab[SLOT_N];
  int unsigned n_entries;
  int unsigned store_fill;
  int unsigned ent_off[ENT_MAX];
  int unsigned ent_len[ENT_MAX];
  logic [15:0] ent_dest[ENT_MAX];
  logic        ent_lower[ENT_MAX];
  logic [7:0]  kstore[STORE_MAX];

  function automatic bit stored_key_equal(int unsigned e);
    if (ent_len[e] != klen) return 0;
    for (int unsigned j = 0; j < klen; j++) begin
      if (ent_off[e] + j >= STORE_MAX) return 0;
      if (kstore[ent_off[e] + j] != kbuf[j]) return 0;
    end
    return 1;
  endfunction

  function automatic void table_wipe();
    foreach (slot_tab[i]) slot_tab[i] = 0;
    n_entries = 0;
    store_fill = 0;
    klen = 0;
    khash = HASH_INIT;
  endfunction

  function automatic void predict_table(key_word_t w);
    skht_res_t   r;
    int unsigned pos, ent, free_slot;
    bit          found;
    if (w.func == FN_RSVD) return;
    r = '0;
    if (w.func == FN_CLEAR) begin
      table_wipe();
      r.status = ST_CLEARED;
      lookup_exp_q.push_back(r);
      return;
    end
    if (klen < KEY_MAX) begin
      kbuf[klen] = w.kbyte;
      klen++;
    end else klen = KEY_MAX + 1;
    khash = (khash ^ {24'd0, w.kbyte}) * HASH_PRIME;
    if (!w.last) return;
    found = 0;
    free_slot = SLOT_N;
    ent = 0;
    if (klen <= KEY_MAX) begin
      pos = khash & (SLOT_N - 1);
      for (int k = 0; k < SLOT_N; k++) begin
        if (slot_tab[pos] == 0) begin
          free_slot = pos;
          break;
        end
        if (slot_tab[pos] - 1 < ENT_MAX && stored_key_equal(slot_tab[pos] - 1)) begin
          found = 1;
          ent = slot_tab[pos] - 1;
          break;
        end
        pos = (pos + 1) & (SLOT_N - 1);
      end
    end
    if (klen > KEY_MAX) r.status = ST_FULL;
    else if (found) begin
      r.status = (w.func == FN_LOOKUP) ? ST_HIT : ST_PRESENT;
      r.entry_index = ent[7:0];
      r.dest = ent_dest[ent];
      r.lower = ent_lower[ent];
    end else if (w.func == FN_LOOKUP) r.status = ST_MISS;
    else if (n_entries >= ENT_MAX || free_slot >= SLOT_N || store_fill > STORE_MAX
             || klen > STORE_MAX - store_fill) r.status = ST_FULL;
    else begin
      for (int unsigned j = 0; j < klen; j++) kstore[store_fill + j] = kbuf[j];
      ent_off[n_entries] = store_fill;
      ent_len[n_entries] = klen;
      ent_dest[n_entries] = w.dest;
      ent_lower[n_entries] = w.lower;
      slot_tab[free_slot] = n_entries + 1;
      store_fill += klen;
      r.status = ST_INSERTED;
      r.entry_index = n_entries[7:0];
      r.dest = w.dest;
      r.lower = w.lower;
      n_entries++;
    end
    klen = 0;
    khash = HASH_INIT;
    lookup_exp_q.push_back(r);
  endfunction

  // queue a whole key; mixed gives the leading bytes random funcs
  task automatic send_key(logic [1:0] fn, key_t k, logic [15:0] dest, logic lower,
                          bit mixed = 0);
    key_word_t w;
    foreach (k[i]) begin
      w.func = fn;
      if (mixed && i != k.size() - 1) w.func = ($urandom_range(0, 1) != 0) ? FN_INSERT : FN_LOOKUP;
      w.kbyte = k[i];
      w.last = (i == k.size() - 1);
      w.dest = w.last ? dest : 16'($urandom);
      w.lower = w.last ? lower : 1'($urandom);
      word_q.push_back(w);
    end
  endtask

  task automatic send_op(logic [1:0] fn);
    key_word_t w;
    w.func = fn;
    w.kbyte = 8'($urandom);
    w.last = 1'($urandom);
    w.dest = 16'($urandom);
    w.lower = 1'($urandom);
    word_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || lookup_exp_q.size() != 0) @(posedge clk);
  endtask

  // driver: bursts of random length with random gaps
  bit pending = 0;
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_push && pending)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_func <= word_q[0].func;
        in_key_byte <= word_q[0].kbyte;
        in_last <= word_q[0].last;
        in_dest_id <= word_q[0].dest;
        in_lower_flag <= word_q[0].lower;
        in_push <= 1'b1;
        pending = 1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full && pending) begin
      key_word_t w;
      w.func = in_func;
      w.kbyte = in_key_byte;
      w.last = in_last;
      w.dest = in_dest_id;
      w.lower = in_lower_flag;
      predict_table(w);
      void'(word_q.pop_front());
      pending = 0;
      words_taken++;
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int  hold_left = 0;
  bit  hold_done = 0;
  int  pop_mode = 0;
  int  mode_left = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!hold_done && words_taken >= 300) begin
        hold_done = 1;
        hold_left = 3000;
        out_pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          pop_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (pop_mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          default: out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (lookup_exp_q.size() == 0) begin
        $display("%0t: unexpected word status %0d", $realtime, out_status);
        errors++;
      end else begin
        skht_res_t e;
        e = lookup_exp_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, out_status);
          errors++;
        end
        if (out_entry_index !== e.entry_index) begin
          $display("%0t: entry_index exp %0d got %0d", $realtime, e.entry_index,
                   out_entry_index);
          errors++;
        end
        if (out_dest_out !== e.dest) begin
          $display("%0t: dest_out exp %h got %h", $realtime, e.dest, out_dest_out);
          errors++;
        end
        if (out_lower_out !== e.lower) begin
          $display("%0t: lower_out exp %0d got %0d", $realtime, e.lower, out_lower_out);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $display("string_key_hash_table test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    key_t k;
    key_t pool[24];
    int   n;
    table_wipe();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_op(FN_CLEAR);
    send_key(FN_LOOKUP, '{8'h61}, 16'h0, 1'b0);
    send_key(FN_INSERT, '{8'h61}, 16'hffff, 1'b1);
    send_key(FN_LOOKUP, '{8'h61}, 16'h0, 1'b0);
    send_key(FN_INSERT, '{8'h61}, 16'h1234, 1'b0);
    send_key(FN_INSERT, '{8'h00, 8'hff}, 16'h0000, 1'b0);
    send_op(FN_RSVD);
    send_key(FN_LOOKUP, '{8'h00, 8'hff}, 16'h0, 1'b1);
    send_key(FN_LOOKUP, '{8'hff, 8'h00}, 16'h0, 1'b0);
    send_key(FN_INSERT, '{8'h55, 8'haa, 8'h0f}, 16'h8001, 1'b1, 1);
    send_key(FN_LOOKUP, '{8'h55, 8'haa, 8'h0f}, 16'h0, 1'b0, 1);
    // partial key dropped by clear
    send_key(FN_INSERT, '{8'h61, 8'h62}, 16'h0, 1'b0);
    void'(word_q.pop_back());
    send_op(FN_CLEAR);
    send_key(FN_LOOKUP, '{8'h61}, 16'h0, 1'b0);
    k = {};
    for (int i = 0; i <= KEY_MAX; i++) k.push_back(8'($urandom));
    send_key(FN_INSERT, k, 16'h7777, 1'b1);

    // random over a small pool of keys so that hits and duplicates occur
    foreach (pool[i]) begin
      n = $urandom_range(1, 6);
      pool[i] = {};
      for (int j = 0; j < n; j++) pool[i].push_back(8'($urandom));
    end
    for (int i = 0; i < 20; i++) begin
      n = $urandom_range(0, 99);
      if (n < 2) send_op(FN_CLEAR);
      else if (n < 5) send_op(FN_RSVD);
      else send_key((n < 50) ? FN_INSERT : FN_LOOKUP, pool[$urandom_range(0, 23)],
                    16'($urandom), 1'($urandom), ($urandom_range(0, 9) == 0));
    end

    // hold the sender until all words are back
    wait_drained();

    // fill the table past its entry limit
    send_op(FN_CLEAR);
    for (int i = 0; i < ENT_MAX + 4; i++) begin
      k = {8'(i)};
      if (i >= ENT_MAX) k.push_back(8'h01);
      send_key(FN_INSERT, k, 16'($urandom), 1'($urandom));
    end
    for (int i = 0; i < 8; i++) begin
      n = $urandom_range(0, ENT_MAX + 6);
      k = {8'(n)};
      if (n >= ENT_MAX) k.push_back(8'h01);
      send_key(FN_LOOKUP, k, 16'h0, 1'b0);
    end
    send_op(FN_CLEAR);
    for (int i = 0; i < 10; i++)
      send_key(($urandom_range(0, 1) != 0) ? FN_INSERT : FN_LOOKUP,
               pool[$urandom_range(0, 23)], 16'($urandom), 1'($urandom));

    wait_drained();
    repeat (SLOT_N + 200) @(posedge clk);
    if (errors == 0 && lookup_exp_q.size() == 0) begin
      $display("string_key_hash_table test passed");
    end else begin
      $display("string_key_hash_table test failed");
    end
    $finish;
  end
endmodule
